### design/nbfs_pkg.sv
// Shared constants, types and helper functions for the nixie BCD frame shifter.
package nbfs_pkg;

   // Default number of BCD digits carried in one frame.
   localparam int DIGIT_COUNT_DEF = 4;

   // Width of the input reading and of its saturated magnitude.
   localparam int READING_W = 28;
   localparam int MAG_W     = 27;

   // Largest magnitude shown on the tubes: 9999.0000 in units of 1/10000.
   localparam logic [MAG_W-1:0] SAT_UNITS = MAG_W'(99990000);

   // Binary to BCD conversion: eight digits, three input bits per cycle.
   localparam int DABBLE_DIGITS = 8;
   localparam int BCD_W         = 4 * DABBLE_DIGITS;
   localparam int BITS_PER_STEP = 3;
   localparam int CONV_STEPS    = MAG_W / BITS_PER_STEP;
   localparam int CONV_CNT_W    = $clog2(CONV_STEPS);

   // Flag byte layout.
   localparam int FLAG_W = 8;
   localparam logic [FLAG_W-1:0] FLAG_NEG      = 8'h80;
   localparam logic [FLAG_W-1:0] FLAG_TEMP     = 8'h40;
   localparam logic [FLAG_W-1:0] FLAG_PRESSURE = 8'h20;
   localparam logic [FLAG_W-1:0] FLAG_HUMIDITY = 8'h10;
   localparam logic [FLAG_W-1:0] FLAG_POINT3   = 8'h01;
   localparam logic [FLAG_W-1:0] FLAG_POINT2   = 8'h02;
   localparam logic [FLAG_W-1:0] FLAG_POINT1   = 8'h04;

   // Measurement mode codes.
   typedef enum logic [1:0] {
      MODE_TEMP     = 2'd0,
      MODE_PRESSURE = 2'd1,
      MODE_HUMIDITY = 2'd2,
      MODE_NONE     = 2'd3
   } nbfs_mode_type;

   // One double-dabble step: correct every digit of five or more, then shift in a bit.
   function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic din);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int d = 0; d < DABBLE_DIGITS; d++) begin
         if (bcd[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], din};
   endfunction

endpackage

### design/nbfs_front.sv
// Front end: takes readings, converts the magnitude to BCD and builds the frame.
module nbfs_front #(
   parameter int DIGIT_COUNT = nbfs_pkg::DIGIT_COUNT_DEF,
   parameter int FRAME_BITS  = 8 + 4 * DIGIT_COUNT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [nbfs_pkg::READING_W-1:0]    req_reading,
   input  logic [1:0]                               req_mode,
   output logic                                     push_valid,
   input  logic                                     push_ready,
   output logic [FRAME_BITS-1:0]                    push_frame
);
   import nbfs_pkg::*;

   localparam int BCD_OUT_W = 4 * DIGIT_COUNT;

   // Holding register for one accepted transaction.
   logic                        pend_valid_ff, pend_valid_in;
   logic [READING_W-1:0]        pend_reading_ff;
   nbfs_mode_type               pend_mode_ff;

   // Converter state.
   logic                        conv_active_ff, conv_active_in;
   logic                        conv_done_ff, conv_done_in;
   logic [CONV_CNT_W-1:0]       conv_cnt_ff, conv_cnt_in;
   logic [MAG_W-1:0]            bin_ff, bin_in;
   logic [BCD_W-1:0]            bcd_ff, bcd_in;
   logic                        neg_ff;
   nbfs_mode_type               mode_ff;

   logic                        accept;
   logic                        start;
   logic                        push;
   logic                        conv_last;
   logic [READING_W-1:0]        mag_full;
   logic [MAG_W-1:0]            mag_sat;
   logic [BCD_W-1:0]            bcd_step;
   logic [1:0]                  lead_zeros;
   logic [BCD_W-1:0]            bcd_aligned;
   logic                        int_nonzero;
   logic [FLAG_W-1:0]           flags;

   // Handshake on the input side.
   assign push      = conv_done_ff & push_ready;
   assign start     = pend_valid_ff & ~conv_active_ff & (~conv_done_ff | push_ready);
   assign req_stall = pend_valid_ff & ~start;
   assign accept    = req_valid & ~req_stall;
   assign pend_valid_in = accept | (pend_valid_ff & ~start);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      if (accept) begin
         pend_reading_ff <= req_reading;
         pend_mode_ff    <= nbfs_mode_type'(req_mode);
      end
   end

   // Magnitude of the reading, saturated at 9999.0000.
   always_comb begin
      mag_full = pend_reading_ff[READING_W-1] ? (READING_W'(0) - pend_reading_ff)
                                              : pend_reading_ff;
      if (mag_full > {1'b0, SAT_UNITS}) begin
         mag_sat = SAT_UNITS;
      end else begin
         mag_sat = mag_full[MAG_W-1:0];
      end
   end

   // Three double-dabble steps per cycle.
   always_comb begin
      bcd_step = bcd_ff;
      for (int j = 0; j < BITS_PER_STEP; j++) begin
         bcd_step = dabble_step(bcd_step, bin_ff[MAG_W-1-j]);
      end
   end

   assign conv_last = (conv_cnt_ff == CONV_CNT_W'(CONV_STEPS - 1));

   // Converter sequencing.
   always_comb begin
      conv_active_in = conv_active_ff;
      conv_done_in   = conv_done_ff & ~push;
      conv_cnt_in    = conv_cnt_ff;
      bin_in         = bin_ff;
      bcd_in         = bcd_ff;
      if (start) begin
         conv_active_in = 1'b1;
         conv_cnt_in    = '0;
         bin_in         = mag_sat;
         bcd_in         = '0;
      end else if (conv_active_ff) begin
         bin_in      = bin_ff << BITS_PER_STEP;
         bcd_in      = bcd_step;
         conv_cnt_in = conv_cnt_ff + CONV_CNT_W'(1);
         if (conv_last) begin
            conv_active_in = 1'b0;
            conv_done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_active_ff <= 1'b0;
         conv_done_ff   <= 1'b0;
         conv_cnt_ff    <= '0;
      end else begin
         conv_active_ff <= conv_active_in;
         conv_done_ff   <= conv_done_in;
         conv_cnt_ff    <= conv_cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      if (start) begin
         neg_ff  <= pend_reading_ff[READING_W-1];
         mode_ff <= pend_mode_ff;
      end
   end

   // Drop leading zeros of the integer part, keeping at least one digit.
   always_comb begin
      priority if (bcd_ff[31:28] != 4'd0) begin
         lead_zeros = 2'd0;
      end else if (bcd_ff[27:24] != 4'd0) begin
         lead_zeros = 2'd1;
      end else if (bcd_ff[23:20] != 4'd0) begin
         lead_zeros = 2'd2;
      end else begin
         lead_zeros = 2'd3;
      end
      bcd_aligned = bcd_ff << {lead_zeros, 2'b00};
      int_nonzero = (bcd_ff[31:16] != 16'd0);
   end

   // Flag byte: sign, mode lamp and decimal point position.
   always_comb begin
      flags = '0;
      if (neg_ff) begin
         flags = flags | FLAG_NEG;
      end
      unique case (mode_ff)
         MODE_TEMP:     flags = flags | FLAG_TEMP;
         MODE_PRESSURE: flags = flags | FLAG_PRESSURE;
         MODE_HUMIDITY: flags = flags | FLAG_HUMIDITY;
         MODE_NONE:     flags = flags;
         default:       flags = flags;
      endcase
      if (int_nonzero) begin
         unique case (lead_zeros)
            2'd1:    flags = flags | FLAG_POINT3;
            2'd2:    flags = flags | FLAG_POINT2;
            2'd3:    flags = flags | FLAG_POINT1;
            default: flags = flags;
         endcase
      end
   end

   assign push_valid = conv_done_ff;
   assign push_frame = {flags, bcd_aligned[BCD_W-1 -: BCD_OUT_W]};

endmodule

### design/nbfs_queue.sv
// Two-entry frame queue between the front end and the serializer.
module nbfs_queue #(
   parameter int FRAME_BITS = 8 + 4 * nbfs_pkg::DIGIT_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [FRAME_BITS-1:0] push_frame,
   output logic                  pop_valid,
   input  logic                  pop,
   output logic [FRAME_BITS-1:0] pop_frame
);
   import nbfs_pkg::*;

   logic [FRAME_BITS-1:0] entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_frame  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

### design/nbfs_back.sv
// Serializer: shifts each frame out MSB first through the output register.
module nbfs_back #(
   parameter int FRAME_BITS = 8 + 4 * nbfs_pkg::DIGIT_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop,
   input  logic [FRAME_BITS-1:0] pop_frame,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_data_bit,
   output logic [4:0]            rsp_bit_index,
   output logic                  rsp_latch_after
);
   import nbfs_pkg::*;

   localparam int IDX_W = ($clog2(FRAME_BITS) > 5) ? $clog2(FRAME_BITS) : 5;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

   logic                  active_ff, active_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  data_bit_ff;
   logic [4:0]            bit_index_ff;
   logic                  latch_after_ff;

   logic                  advance;
   logic                  emit;
   logic [FRAME_BITS-1:0] cur_frame;
   logic [IDX_W-1:0]      cur_idx;

   // The output register moves when it is empty or its transaction is taken.
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign cur_frame = active_ff ? shift_ff : pop_frame;
   assign cur_idx   = active_ff ? idx_ff : '0;
   assign emit      = advance & (active_ff | pop_valid);
   assign pop       = emit & ~active_ff;

   // Next bit of the current frame, or the first bit of the queued one.
   always_comb begin
      active_in    = active_ff;
      shift_in     = shift_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
         shift_in     = cur_frame << 1;
         idx_in       = cur_idx + IDX_W'(1);
         active_in    = (cur_idx != LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff <= shift_in;
      if (emit) begin
         data_bit_ff    <= cur_frame[FRAME_BITS-1];
         bit_index_ff   <= cur_idx[4:0];
         latch_after_ff <= (cur_idx == LAST_IDX);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_bit    = data_bit_ff;
   assign rsp_bit_index   = bit_index_ff;
   assign rsp_latch_after = latch_after_ff;

endmodule

### design/nixie_bcd_frame_shifter.sv
// Top level of the nixie BCD frame shifter: front end, frame queue and serializer.
//
// Each accepted reading (signed, in units of 1/10000, magnitude clipped at 9999.0000)
// becomes one frame of 8 + 4*DIGIT_COUNT bits (24 by default): a flag byte with sign,
// mode lamp and decimal point, followed by the leading BCD digits of the value. The
// frame leaves one bit per transaction, MSB first, with latch_after set on the last bit.
// The serializer sets the pace: while rsp_stall is low and the queue holds a frame, frames
// follow each other without a gap. The front end handles each reading in steps (capture,
// a binary to BCD conversion at three bits per cycle, and the queue push) and works on
// the next reading while a two-frame queue feeds the serializer. A reading passes the
// holding register, the converter, the queue and the output register before its first bit leaves.
module nixie_bcd_frame_shifter #(
   parameter int DIGIT_COUNT = nbfs_pkg::DIGIT_COUNT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [nbfs_pkg::READING_W-1:0] req_reading,
   input  logic [1:0]                            req_mode,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_data_bit,
   output logic [4:0]                            rsp_bit_index,
   output logic                                  rsp_latch_after
);
   import nbfs_pkg::*;

   localparam int FRAME_BITS = FLAG_W + 4 * DIGIT_COUNT;

   logic                  push_valid;
   logic                  push_ready;
   logic [FRAME_BITS-1:0] push_frame;
   logic                  pop_valid;
   logic                  pop;
   logic [FRAME_BITS-1:0] pop_frame;

   // Conversion and frame assembly.
   nbfs_front #(
      .DIGIT_COUNT (DIGIT_COUNT),
      .FRAME_BITS  (FRAME_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_reading (req_reading),
      .req_mode    (req_mode),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_frame  (push_frame)
   );

   // Frames waiting for the serializer.
   nbfs_queue #(
      .FRAME_BITS (FRAME_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_frame  (pop_frame)
   );

   // Bit-serial output.
   nbfs_back #(
      .FRAME_BITS (FRAME_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop             (pop),
      .pop_frame       (pop_frame),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_bit    (rsp_data_bit),
      .rsp_bit_index   (rsp_bit_index),
      .rsp_latch_after (rsp_latch_after)
   );

endmodule
